// ===== rtl/core/rbd_pkg.sv =====
// ----------------------------------------------------------------------------
// rbd_pkg
// Shared types and constants of the 2x2 RGBA box downsampler.
// ----------------------------------------------------------------------------
package rbd_pkg;

    localparam int CHAN_N   = 4;
    localparam int CHAN_W   = 8;
    localparam int PIX_W    = CHAN_N * CHAN_W;
    localparam int PSUM_W   = CHAN_W + 1;
    localparam int LINE_W   = CHAN_N * PSUM_W;
    localparam int SIZE_W   = 11;
    localparam int POS_W    = SIZE_W + 1;
    localparam int CFG_IDX_W = 1;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_HEIGHT = 1'd1;

    typedef logic [PIX_W-1:0]  pixel_t;
    typedef logic [LINE_W-1:0] line_entry_t;
    typedef logic [SIZE_W-1:0] size_t;
    typedef logic [POS_W-1:0]  pos_t;

endpackage

// ===== rtl/core/rgba_box_downsample_2x.sv =====
// ----------------------------------------------------------------------------
// rgba_box_downsample_2x
// 2x2 box-filter downsampler for an RGBA pixel stream in raster order.
// ----------------------------------------------------------------------------
// The block takes one source pixel per clock while the output is not stalled and
// gives one output pixel for every 2x2 source block, on the right pixel of the
// pair on the odd row; tlast marks the last output pixel of the frame. An output
// passes the stage 1 and output registers to m_tvalid. The rate is set by
// the single-port line memory (MAX_OUT_WIDTH entries of 36 bits): an even row
// writes one pair sum per pixel pair, an odd row reads one back, so each pixel
// needs at most one memory access and the stream runs at one pixel per clock
// while the consumer keeps m_tready high. The memory needs no clearing after
// reset, since every entry read on an odd row was written on the row before.
// A configuration write restarts the frame at the top-left source pixel; a
// size of zero is taken as one and sizes above the maximum are saturated.
// ----------------------------------------------------------------------------
module rgba_box_downsample_2x #(
    parameter int MAX_OUT_WIDTH  = 1024,
    parameter int MAX_OUT_HEIGHT = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [rbd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rbd_pkg::SIZE_W-1:0]        cfg_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // in_red [7:0], in_green [15:8], in_blue [23:16], in_alpha [31:24]
    input  logic [rbd_pkg::PIX_W-1:0]         s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // out_red [7:0], out_green [15:8], out_blue [23:16], out_alpha [31:24]
    output logic [rbd_pkg::PIX_W-1:0]         m_tdata,
    // frame_end
    output logic                              m_tlast
);

    localparam int ADDR_W = (MAX_OUT_WIDTH > 1) ? $clog2(MAX_OUT_WIDTH) : 1;
    localparam int SIZE_MAX = (1 << rbd_pkg::SIZE_W) - 1;
    localparam int W_CAP = (MAX_OUT_WIDTH > SIZE_MAX) ? SIZE_MAX : MAX_OUT_WIDTH;
    localparam int H_CAP = (MAX_OUT_HEIGHT > SIZE_MAX) ? SIZE_MAX : MAX_OUT_HEIGHT;
    localparam rbd_pkg::size_t W_CAP_V = rbd_pkg::SIZE_W'(W_CAP);
    localparam rbd_pkg::size_t H_CAP_V = rbd_pkg::SIZE_W'(H_CAP);
    localparam rbd_pkg::size_t SIZE_ONE = rbd_pkg::SIZE_W'(1);

    rbd_pkg::size_t      out_width_reg, out_height_reg;
    rbd_pkg::size_t      cfg_w_clamped, cfg_h_clamped;
    rbd_pkg::pos_t       col_reg, col_next, row_reg, row_next;
    rbd_pkg::pos_t       src_w_last, src_h_last;
    rbd_pkg::pixel_t     left_pixel_reg;
    rbd_pkg::line_entry_t pair_sum;
    rbd_pkg::line_entry_t line_mem [MAX_OUT_WIDTH];
    rbd_pkg::line_entry_t rd_data_reg, s1_psum_reg;
    logic                s1_valid_reg, s1_last_reg;
    logic                out_valid_reg, out_last_reg;
    rbd_pkg::pixel_t     out_data_reg, out_data_next;
    logic [ADDR_W-1:0]   slot;
    logic                in_acc, s1_move, is_pair, last_col, last_row;
    logic                do_write, do_read;

    // ---------------------------------------------------------------- config
    always_comb
    begin
        cfg_w_clamped = cfg_data;
        if (cfg_data == '0)
        begin
            cfg_w_clamped = SIZE_ONE;
        end
        else if (cfg_data > W_CAP_V)
        begin
            cfg_w_clamped = W_CAP_V;
        end
        cfg_h_clamped = cfg_data;
        if (cfg_data == '0)
        begin
            cfg_h_clamped = SIZE_ONE;
        end
        else if (cfg_data > H_CAP_V)
        begin
            cfg_h_clamped = H_CAP_V;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_width_reg  <= W_CAP_V;
            out_height_reg <= H_CAP_V;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rbd_pkg::CFG_OUT_WIDTH:  out_width_reg  <= cfg_w_clamped;
                rbd_pkg::CFG_OUT_HEIGHT: out_height_reg <= cfg_h_clamped;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------- handshake
    assign s1_move  = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_move;
    assign in_acc   = s_tvalid && s_tready;

    // -------------------------------------------------------- raster position
    assign src_w_last = {out_width_reg, 1'b0} - rbd_pkg::POS_W'(1);
    assign src_h_last = {out_height_reg, 1'b0} - rbd_pkg::POS_W'(1);
    assign last_col   = (col_reg == src_w_last);
    assign last_row   = (row_reg == src_h_last);
    assign is_pair    = col_reg[0];
    assign slot       = ADDR_W'(col_reg >> 1);
    assign do_write   = in_acc && is_pair && !row_reg[0];
    assign do_read    = in_acc && is_pair && row_reg[0];

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (in_acc)
        begin
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + rbd_pkg::POS_W'(1);
            end
            else
            begin
                col_next = col_reg + rbd_pkg::POS_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (cfg_we && (cfg_index == rbd_pkg::CFG_OUT_WIDTH ||
                            cfg_index == rbd_pkg::CFG_OUT_HEIGHT))
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_pixel_reg <= '0;
        end
        else if (in_acc && !is_pair)
        begin
            left_pixel_reg <= s_tdata;
        end
    end

    // Horizontal pair sum, four 9-bit fields.
    always_comb
    begin
        for (int c = 0; c < rbd_pkg::CHAN_N; c++)
        begin
            pair_sum[c*rbd_pkg::PSUM_W +: rbd_pkg::PSUM_W] =
                {1'b0, left_pixel_reg[c*rbd_pkg::CHAN_W +: rbd_pkg::CHAN_W]} +
                {1'b0, s_tdata[c*rbd_pkg::CHAN_W +: rbd_pkg::CHAN_W]};
        end
    end

    // ------------------------------------------------------------ line memory
    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            line_mem[slot] <= pair_sum;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_read)
        begin
            rd_data_reg <= line_mem[slot];
        end
    end

    // ---------------------------------------------------------------- stage 1
    always_ff @(posedge clk)
    begin
        if (do_read)
        begin
            s1_psum_reg <= pair_sum;
            s1_last_reg <= last_col && last_row;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (do_read)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    // Vertical sum plus 2, divided by 4: rounds halves up.
    always_comb
    begin
        logic [rbd_pkg::PSUM_W:0] vsum;
        for (int c = 0; c < rbd_pkg::CHAN_N; c++)
        begin
            vsum = {1'b0, rd_data_reg[c*rbd_pkg::PSUM_W +: rbd_pkg::PSUM_W]} +
                   {1'b0, s1_psum_reg[c*rbd_pkg::PSUM_W +: rbd_pkg::PSUM_W]} +
                   (rbd_pkg::PSUM_W+1)'(2);
            out_data_next[c*rbd_pkg::CHAN_W +: rbd_pkg::CHAN_W] = vsum[rbd_pkg::PSUM_W:2];
        end
    end

    // ----------------------------------------------------------- output stage
    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            out_data_reg <= out_data_next;
            out_last_reg <= s1_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_move)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ===== rtl/core/rbd_checker.sv =====
// ----------------------------------------------------------------------------
// rbd_checker
// Port-level checks of the 2x2 RGBA box downsampler.
// ----------------------------------------------------------------------------
module rbd_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [rbd_pkg::PIX_W-1:0]     m_tdata,
    input logic                          m_tlast
);

    // No result may be shown while reset is held.
    a_reset_quiet: assert property (@(posedge clk) !rst_n |-> !m_tvalid)
        else $error("m_tvalid high during reset");

    // A stalled output transaction keeps its contents.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output changed while stalled");

    // The input side only stalls when a finished result is waiting downstream.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without output backpressure");

endmodule

bind rgba_box_downsample_2x rbd_checker u_rbd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// ===== test/rgba_box_downsample_2x_tb.sv =====
// ----------------------------------------------------------------------------
// rgba_box_downsample_2x_tb
// Self-checking testbench of the 2x2 RGBA box downsampler.
// ----------------------------------------------------------------------------
// Source pixels are sent over the slave stream with random gaps, and output
// pixels are taken from the master stream with random stalls. A predictor in
// the testbench follows the raster position and line of pair sums. For every
// accepted source pixel that completes a block it queues that block's mean.
// Each output transaction is checked channel by channel, and tlast is checked
// against the queued value. Directed tests cover the reset size, rounding,
// the size limits, restarts by register writes and output stalls. Random
// frames of mostly small sizes follow.
// ----------------------------------------------------------------------------
module rgba_box_downsample_2x_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_W        = 1024;
    localparam int MAX_H        = 1024;
    localparam int SETTLE       = 8;
    localparam int MAX_GAP      = 11;
    localparam int RANDOM_ITEMS = 660;
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int PRINT_LIMIT  = 100;

    typedef struct packed {
        logic            last;
        rbd_pkg::pixel_t pix;
    } box_result_t;

    logic                          clk       = 1'b0;
    logic                          rst_n;
    logic                          cfg_we    = 1'b0;
    logic [rbd_pkg::CFG_IDX_W-1:0] cfg_index = rbd_pkg::CFG_OUT_WIDTH;
    rbd_pkg::size_t                cfg_data  = '0;
    logic                          s_tvalid  = 1'b0;
    logic                          s_tready;
    rbd_pkg::pixel_t               s_tdata   = '0;
    logic                          m_tvalid;
    logic                          m_tready  = 1'b0;
    rbd_pkg::pixel_t               m_tdata;
    logic                          m_tlast;

    // Predictor state.
    int unsigned          cfg_out_w;
    int unsigned          cfg_out_h;
    int unsigned          pix_col;
    int unsigned          pix_row;
    rbd_pkg::pixel_t      left_px;
    rbd_pkg::line_entry_t pair_sums [MAX_W];
    box_result_t          box_mean_q [$];

    int unsigned   error_count  = 0;
    int unsigned   output_count = 0;
    int unsigned   cycle_count  = 0;
    int            hold_len     = 0;
    bit            send_gaps    = 1'b1;
    bit            recv_gaps    = 1'b1;

    string chan_name [rbd_pkg::CHAN_N] = '{"red", "green", "blue", "alpha"};

    rgba_box_downsample_2x #(
        .MAX_OUT_WIDTH  (MAX_W),
        .MAX_OUT_HEIGHT (MAX_H)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("rgba_box_downsample_2x regression: fail");
            $finish;
        end
    end

    task automatic report_mismatch(input string field, input int unsigned got,
                                   input int unsigned want);
        if (error_count < PRINT_LIMIT)
            $display("output %0d: %s is %0d, expected %0d", output_count, field, got, want);
        error_count++;
    endtask

    function automatic int unsigned clamp_dim(input rbd_pkg::size_t v,
                                              input int unsigned maxv);
        int unsigned s;
        s = v;
        if (s == 0)
            s = 1;
        if (s > maxv)
            s = maxv;
        return s;
    endfunction

    // Advances the predicted raster position by one source pixel and queues
    // the block mean when the pixel is the right one of a pair on an odd row.
    function automatic void accept_pixel(input rbd_pkg::pixel_t pix);
        rbd_pkg::line_entry_t pair;
        box_result_t          res;
        int unsigned          sum;
        if (pix_col % 2 == 0)
            left_px = pix;
        else
        begin
            for (int c = 0; c < rbd_pkg::CHAN_N; c++)
                pair[c*rbd_pkg::PSUM_W +: rbd_pkg::PSUM_W] =
                    rbd_pkg::PSUM_W'(left_px[c*rbd_pkg::CHAN_W +: rbd_pkg::CHAN_W])
                    + rbd_pkg::PSUM_W'(pix[c*rbd_pkg::CHAN_W +: rbd_pkg::CHAN_W]);
            if (pix_row % 2 == 0)
                pair_sums[pix_col / 2] = pair;
            else
            begin
                for (int c = 0; c < rbd_pkg::CHAN_N; c++)
                begin
                    sum = pair_sums[pix_col / 2][c*rbd_pkg::PSUM_W +: rbd_pkg::PSUM_W]
                        + pair[c*rbd_pkg::PSUM_W +: rbd_pkg::PSUM_W];
                    res.pix[c*rbd_pkg::CHAN_W +: rbd_pkg::CHAN_W] =
                        rbd_pkg::CHAN_W'((sum + 2) / 4);
                end
                res.last = (pix_col == 2 * cfg_out_w - 1) && (pix_row == 2 * cfg_out_h - 1);
                box_mean_q.push_back(res);
            end
        end
        pix_col++;
        if (pix_col >= 2 * cfg_out_w)
        begin
            pix_col = 0;
            pix_row++;
            if (pix_row >= 2 * cfg_out_h)
                pix_row = 0;
        end
    endfunction

    function automatic rbd_pkg::pixel_t rand_pixel();
        rbd_pkg::pixel_t p;
        for (int c = 0; c < rbd_pkg::CHAN_N; c++)
            case ($urandom_range(0, 5))
                0:       p[c*rbd_pkg::CHAN_W +: rbd_pkg::CHAN_W] = 8'h00;
                1:       p[c*rbd_pkg::CHAN_W +: rbd_pkg::CHAN_W] = 8'hFF;
                default: p[c*rbd_pkg::CHAN_W +: rbd_pkg::CHAN_W] = rbd_pkg::CHAN_W'($urandom);
            endcase
        return p;
    endfunction

    // Valid is only lowered when a gap follows, so back-to-back pixels keep
    // it high without a second assignment in the same step.
    task automatic send_pixel(input rbd_pkg::pixel_t pix);
        int gap;
        gap = send_gaps ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        do
            @(posedge clk);
        while (!s_tready);
        accept_pixel(pix);
    endtask

    task automatic send_random(input int n);
        for (int i = 0; i < n; i++)
            send_pixel(rand_pixel());
    endtask

    task automatic drain_outputs();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (box_mean_q.size() != 0);
    endtask

    // All queued outputs are drained and the SETTLE wait is kept before the
    // register write, which restarts the predictor at the top-left pixel.
    task automatic write_reg(input logic [rbd_pkg::CFG_IDX_W-1:0] idx,
                             input rbd_pkg::size_t val);
        drain_outputs();
        repeat (SETTLE) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        if (idx == rbd_pkg::CFG_OUT_WIDTH)
            cfg_out_w = clamp_dim(val, MAX_W);
        else
            cfg_out_h = clamp_dim(val, MAX_H);
        pix_col = 0;
        pix_row = 0;
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_size(input rbd_pkg::size_t w, input rbd_pkg::size_t h);
        write_reg(rbd_pkg::CFG_OUT_WIDTH, w);
        write_reg(rbd_pkg::CFG_OUT_HEIGHT, h);
    endtask

    // Output side: a random stall before each transaction while recv_gaps is set, plus any long hold requested.
    initial
    begin : output_sink
        int stall;
        forever
        begin
            stall = hold_len + (recv_gaps ? $urandom_range(0, MAX_GAP) : 0);
            hold_len = 0;
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!(m_tvalid && m_tready));
        end
    end

    always @(posedge clk)
    begin : check_outputs
        box_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (box_mean_q.size() == 0)
                report_mismatch("unexpected pixel", m_tdata, 0);
            else
            begin
                want = box_mean_q.pop_front();
                for (int c = 0; c < rbd_pkg::CHAN_N; c++)
                    if (m_tdata[c*rbd_pkg::CHAN_W +: rbd_pkg::CHAN_W] !==
                        want.pix[c*rbd_pkg::CHAN_W +: rbd_pkg::CHAN_W])
                        report_mismatch(chan_name[c],
                                        m_tdata[c*rbd_pkg::CHAN_W +: rbd_pkg::CHAN_W],
                                        want.pix[c*rbd_pkg::CHAN_W +: rbd_pkg::CHAN_W]);
                if (m_tlast !== want.last)
                    report_mismatch("frame end", m_tlast, want.last);
            end
            output_count++;
        end
    end

    // The reset size is 1024 x 1024, so a source row holds 2048 pixels and a
    // short run at the start of the first row gives no output.
    task automatic test_reset_size();
        send_random(48);
    endtask

    // Single-block frames; writing zero to both sizes selects 1 x 1.
    task automatic test_block_rounding();
        rbd_pkg::pixel_t px [20];
        px = '{32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000,
               32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
               32'h02010101, 32'h01010100, 32'h00010000, 32'h00000000,
               32'hFF00FF00, 32'h00FF00FF, 32'hFF00FF00, 32'h00FF00FF,
               32'h01FE807F, 32'hFE0180FF, 32'h7F80FE01, 32'h80FF01FE};
        set_size('0, '0);
        foreach (px[i])
            send_pixel(px[i]);
    endtask

    // Oversized writes saturate; each shape runs the start of a frame.
    task automatic test_size_saturation();
        set_size(11'd2047, 11'd0);
        send_random(40);
        set_size(11'd1, 11'd1025);
        send_random(64);
    endtask

    // A write to either register mid-frame starts over at the top left.
    task automatic test_restart_mid_frame();
        set_size(11'd3, 11'd2);
        send_random(17);
        write_reg(rbd_pkg::CFG_OUT_HEIGHT, 11'd2);
        send_random(24);
        send_random(7);
        write_reg(rbd_pkg::CFG_OUT_WIDTH, 11'd3);
        send_random(24);
    endtask

    task automatic test_output_stall();
        set_size(11'd8, 11'd4);
        send_gaps = 1'b0;
        hold_len = 300;
        send_random(256);
        send_gaps = 1'b1;
    endtask

    task automatic test_drain_pause();
        set_size(11'd5, 11'd3);
        send_random(33);
        drain_outputs();
        send_random(62);
    endtask

    function automatic rbd_pkg::size_t pick_dim();
        int r;
        r = $urandom_range(0, 19);
        if (r < 14)
            return rbd_pkg::size_t'($urandom_range(1, 4));
        else if (r < 19)
            return rbd_pkg::size_t'($urandom_range(5, 16));
        return rbd_pkg::size_t'($urandom_range(17, 64));
    endfunction

    task automatic test_random_frames();
        int sent;
        int frame_px;
        int n;
        int pause_at;
        sent = 0;
        set_size(pick_dim(), pick_dim());
        while (sent < RANDOM_ITEMS)
        begin
            send_gaps = ($urandom_range(0, 3) != 0);
            recv_gaps = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 3))
                0:       write_reg(rbd_pkg::CFG_OUT_WIDTH, pick_dim());
                1:       write_reg(rbd_pkg::CFG_OUT_HEIGHT, pick_dim());
                default: set_size(pick_dim(), pick_dim());
            endcase
            frame_px = 4 * cfg_out_w * cfg_out_h;
            // Large frames are cut short after between two source rows and 512 pixels;
            // the next write restarts them anyway.
            if (frame_px > 512)
                n = $urandom_range(4 * cfg_out_w, 512);
            else
            begin
                n = frame_px * $urandom_range(1, 3);
                if ($urandom_range(0, 1) == 1)
                    n += $urandom_range(0, frame_px - 1);
            end
            if (n > RANDOM_ITEMS - sent)
                n = RANDOM_ITEMS - sent;
            pause_at = ($urandom_range(0, 7) == 0) ? $urandom_range(0, n - 1) : -1;
            for (int i = 0; i < n; i++)
            begin
                if (i == pause_at)
                    drain_outputs();
                send_pixel(rand_pixel());
            end
            sent += n;
        end
        send_gaps = 1'b1;
        recv_gaps = 1'b1;
    endtask

    initial
    begin
        rst_n     = 1'b0;
        cfg_out_w = MAX_W;
        cfg_out_h = MAX_H;
        pix_col   = 0;
        pix_row   = 0;
        left_px   = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_size();
        test_block_rounding();
        test_size_saturation();
        test_restart_mid_frame();
        test_output_stall();
        test_drain_pause();
        test_random_frames();

        drain_outputs();
        repeat (SETTLE) @(posedge clk);
        if (box_mean_q.size() != 0)
            report_mismatch("outputs missing", 0, box_mean_q.size());
        if (error_count == 0)
            $display("rgba_box_downsample_2x regression: pass");
        else
            $display("rgba_box_downsample_2x regression: fail");
        $finish;
    end

endmodule

// ===== rgba_box_downsample_2x.f =====
rtl/core/rbd_pkg.sv
rtl/core/rgba_box_downsample_2x.sv
rtl/core/rbd_checker.sv
test/rgba_box_downsample_2x_tb.sv
